// File: rtl/core/kwp_pkg.sv
// Shared types, codes and the control store of the keyed table weighted pick block.
package kwp_pkg;

	// Fixed field widths of the request and result channels.
	localparam int KEY_W     = 64;
	localparam int MOVE_W    = 16;
	localparam int RND_W     = 32;
	localparam int FUNC_W    = 2;
	localparam int STAT_W    = 2;
	localparam int IN_DATA_W = KEY_W + MOVE_W + RND_W;

	// Request function codes.
	localparam logic [FUNC_W-1:0] FN_CLEAR  = 2'd0;
	localparam logic [FUNC_W-1:0] FN_INSERT = 2'd1;
	localparam logic [FUNC_W-1:0] FN_LOOKUP = 2'd2;

	// Result status codes.
	localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
	localparam logic [STAT_W-1:0] STAT_MISS = 2'd1;
	localparam logic [STAT_W-1:0] STAT_FULL = 2'd2;

	// Datapath operations selected by a control word.
	typedef enum logic [3:0] {
		OP_NOP,
		OP_START,
		OP_CLEAR,
		OP_SCAN_INS,
		OP_APPEND,
		OP_SCAN_SUM,
		OP_TAKE_FIRST,
		OP_MOD_START,
		OP_SCAN_PICK,
		OP_MISS,
		OP_EMIT
	} uop_t;

	// Jump conditions of the sequencer.
	typedef enum logic [3:0] {
		C_NEVER,
		C_ALWAYS,
		C_NO_REQ,
		C_FUNC_CLR,
		C_FUNC_INS,
		C_FUNC_LKP,
		C_KEY_ZERO,
		C_SCAN_RUN,
		C_FOUND,
		C_NO_MATCH,
		C_ONE_MATCH,
		C_MOD_RUN,
		C_OUT_BUSY
	} ucond_t;

	localparam int UPC_W = 5;
	typedef logic [UPC_W-1:0] upc_t;

	// Control store addresses.
	localparam upc_t U_IDLE     = 5'd0;
	localparam upc_t U_DISP_CLR = 5'd1;
	localparam upc_t U_DISP_INS = 5'd2;
	localparam upc_t U_DISP_LKP = 5'd3;
	localparam upc_t U_OTHER    = 5'd4;
	localparam upc_t U_CLR      = 5'd5;
	localparam upc_t U_INS      = 5'd6;
	localparam upc_t U_INS_SCAN = 5'd7;
	localparam upc_t U_INS_TAIL = 5'd8;
	localparam upc_t U_APPEND   = 5'd9;
	localparam upc_t U_LKP      = 5'd10;
	localparam upc_t U_SUM      = 5'd11;
	localparam upc_t U_CHK      = 5'd12;
	localparam upc_t U_ONE      = 5'd13;
	localparam upc_t U_MODS     = 5'd14;
	localparam upc_t U_MODW     = 5'd15;
	localparam upc_t U_PICK     = 5'd16;
	localparam upc_t U_PEND     = 5'd17;
	localparam upc_t U_MISS     = 5'd18;
	localparam upc_t U_EMIT     = 5'd19;
	localparam upc_t U_DONE     = 5'd20;

	// One control word: an operation, a condition and the jump target taken when it holds.
	typedef struct packed {
		uop_t   op;
		ucond_t cond;
		upc_t   target;
	} uword_t;

	// Read-only program. When the condition is false the sequencer steps to the next word.
	function automatic uword_t ucode_rom(upc_t pc);
		uword_t w;
		unique case (pc)
			U_IDLE:     w = '{OP_START,      C_NO_REQ,    U_IDLE};
			U_DISP_CLR: w = '{OP_NOP,        C_FUNC_CLR,  U_CLR};
			U_DISP_INS: w = '{OP_NOP,        C_FUNC_INS,  U_INS};
			U_DISP_LKP: w = '{OP_NOP,        C_FUNC_LKP,  U_LKP};
			U_OTHER:    w = '{OP_NOP,        C_ALWAYS,    U_EMIT};
			U_CLR:      w = '{OP_CLEAR,      C_ALWAYS,    U_EMIT};
			U_INS:      w = '{OP_NOP,        C_KEY_ZERO,  U_EMIT};
			U_INS_SCAN: w = '{OP_SCAN_INS,   C_SCAN_RUN,  U_INS_SCAN};
			U_INS_TAIL: w = '{OP_NOP,        C_FOUND,     U_EMIT};
			U_APPEND:   w = '{OP_APPEND,     C_ALWAYS,    U_EMIT};
			U_LKP:      w = '{OP_NOP,        C_KEY_ZERO,  U_MISS};
			U_SUM:      w = '{OP_SCAN_SUM,   C_SCAN_RUN,  U_SUM};
			U_CHK:      w = '{OP_NOP,        C_NO_MATCH,  U_MISS};
			U_ONE:      w = '{OP_TAKE_FIRST, C_ONE_MATCH, U_EMIT};
			U_MODS:     w = '{OP_MOD_START,  C_NEVER,     U_IDLE};
			U_MODW:     w = '{OP_NOP,        C_MOD_RUN,   U_MODW};
			U_PICK:     w = '{OP_SCAN_PICK,  C_SCAN_RUN,  U_PICK};
			U_PEND:     w = '{OP_NOP,        C_ALWAYS,    U_EMIT};
			U_MISS:     w = '{OP_MISS,       C_NEVER,     U_IDLE};
			U_EMIT:     w = '{OP_EMIT,       C_OUT_BUSY,  U_EMIT};
			U_DONE:     w = '{OP_NOP,        C_ALWAYS,    U_IDLE};
			default:    w = '{OP_NOP,        C_ALWAYS,    U_IDLE};
		endcase
		return w;
	endfunction

endpackage

// File: rtl/core/kwp_mod.sv
// Iterative restoring modulo unit: one dividend bit per cycle.
module kwp_mod import kwp_pkg::*; #(
	parameter int TOTAL_W = 26
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [RND_W-1:0]   dividend,
	input  logic [TOTAL_W-1:0] divisor,
	output logic               busy,
	output logic [TOTAL_W-1:0] remainder
);

	localparam int CNT_W = $clog2(RND_W + 1);

	logic [CNT_W-1:0]   cnt_q;
	logic [RND_W-1:0]   shift_q;
	logic [TOTAL_W-1:0] rem_q;
	logic [TOTAL_W:0]   trial;
	logic [TOTAL_W:0]   divisor_x;

	// Partial remainder with the next dividend bit shifted in.
	assign trial     = {rem_q, shift_q[RND_W-1]};
	assign divisor_x = {1'b0, divisor};
	assign busy      = (cnt_q != '0);
	assign remainder = rem_q;

	// Bit counter; the unit is busy while it is nonzero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(RND_W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// Compare and subtract step on the partial remainder.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q   <= '0;
			shift_q <= dividend;
		end else if (cnt_q != '0) begin
			shift_q <= shift_q << 1;
			if (trial >= divisor_x) begin
				rem_q <= TOTAL_W'(trial - divisor_x);
			end else begin
				rem_q <= trial[TOTAL_W-1:0];
			end
		end
	end

endmodule

// File: rtl/core/keyed_table_weighted_pick.sv
// Keyed move table with insert, clear and count-weighted random lookup.
//
// Requests arrive on the s_ stream: s_tuser carries the function (clear, insert,
// look up, or an unused code that does nothing) and s_tdata the key, move and
// random value. Every request yields exactly one result on the m_ stream: the
// chosen move on m_tdata and the status on m_tuser.
// A request is taken only while the control sequencer sits at its idle step,
// so one request is in work at a time. Each table pass reads one slot per cycle
// from the table memory, and only filled slots (a fill count of U)
// are visited. Clear, an unused code, and an insert or lookup with a zero key make no
// table pass; any other insert makes one pass, a lookup miss or a single-match hit
// one pass, and a multi-match lookup two passes with a wait on the modulo unit
// between them, so the work grows with U (a full table holds 1024 slots by default).
// The result sits in an output register; while the receiver stalls, the next
// request is still taken and worked on, and only its own result waits for
// the register to empty.
// Reset empties the table at once through the fill count; no clearing pass
// is run and the first request can be taken right after reset.
module keyed_table_weighted_pick import kwp_pkg::*; #(
	parameter int TABLE_DEPTH = 1024,
	parameter int HIT_BITS    = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [IN_DATA_W-1:0] s_tdata,  // position_key, move_code, random_value
	input  logic [FUNC_W-1:0]    s_tuser,  // func
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [MOVE_W-1:0]    m_tdata,  // chosen_move
	output logic [STAT_W-1:0]    m_tuser   // status
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int TW = HIT_BITS + AW;

	// Table memory, one row per slot.
	logic [KEY_W-1:0]    key_mem  [TABLE_DEPTH];
	logic [MOVE_W-1:0]   move_mem [TABLE_DEPTH];
	logic [HIT_BITS-1:0] hits_mem [TABLE_DEPTH];

	// Sequencer and request registers.
	upc_t              upc_q;
	upc_t              upc_next;
	uword_t            uw;
	logic              take;
	logic [FUNC_W-1:0] func_q;
	logic [KEY_W-1:0]  key_q;
	logic [MOVE_W-1:0] move_q;
	logic [RND_W-1:0]  rnd_q;

	// Scan state.
	logic [CW-1:0]       used_q;
	logic [CW-1:0]       idx_q;
	logic                rd_vld_s1;
	logic [AW-1:0]       rd_idx_s1;
	logic [KEY_W-1:0]    rd_key_s1;
	logic [MOVE_W-1:0]   rd_move_s1;
	logic [HIT_BITS-1:0] rd_hits_s1;
	logic                found_q;
	logic [1:0]          nmatch_q;
	logic [TW-1:0]       total_q;
	logic [TW-1:0]       cum_q;
	logic [MOVE_W-1:0]   first_move_q;
	logic [MOVE_W-1:0]   res_move_q;
	logic [STAT_W-1:0]   res_status_q;

	// Output register.
	logic              m_tvalid_q;
	logic [MOVE_W-1:0] m_tdata_q;
	logic [STAT_W-1:0] m_tuser_q;

	// Datapath decode.
	logic                accept;
	logic                scan_op;
	logic                issue;
	logic                key_hit;
	logic                ins_hit;
	logic                pick_hit;
	logic [TW-1:0]       pick_cum;
	logic                table_full;
	logic                append_we;
	logic                mem_we;
	logic [AW-1:0]       mem_waddr;
	logic [HIT_BITS-1:0] mem_whits;
	logic [HIT_BITS-1:0] hits_inc;
	logic                scan_run;
	logic                out_busy;
	logic                mod_busy;
	logic [TW-1:0]       mod_rem;

	assign uw       = ucode_rom(upc_q);
	assign s_tready = (upc_q == U_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	// Slot evaluation for the three kinds of table pass.
	assign scan_op    = (uw.op == OP_SCAN_INS) || (uw.op == OP_SCAN_SUM) ||
	                    (uw.op == OP_SCAN_PICK);
	assign issue      = scan_op && (idx_q < used_q);
	assign key_hit    = rd_vld_s1 && (rd_key_s1 == key_q);
	assign ins_hit    = key_hit && !found_q && (rd_move_s1 == move_q) &&
	                    (uw.op == OP_SCAN_INS);
	assign pick_cum   = cum_q + TW'(rd_hits_s1);
	assign pick_hit   = key_hit && !found_q && (uw.op == OP_SCAN_PICK) && (mod_rem < pick_cum);
	assign table_full = (used_q == CW'(TABLE_DEPTH));
	assign append_we  = (uw.op == OP_APPEND) && !table_full;
	assign hits_inc   = (&rd_hits_s1) ? rd_hits_s1 : rd_hits_s1 + 1'b1;
	assign mem_we     = ins_hit || append_we;
	assign mem_waddr  = ins_hit ? rd_idx_s1 : used_q[AW-1:0];
	assign mem_whits  = ins_hit ? hits_inc : HIT_BITS'(1);
	assign scan_run   = !found_q && (rd_vld_s1 || (idx_q < used_q));
	assign out_busy   = m_tvalid_q && !m_tready;

	// Jump condition select and next step.
	always_comb begin
		unique case (uw.cond)
			C_NEVER:     take = 1'b0;
			C_ALWAYS:    take = 1'b1;
			C_NO_REQ:    take = !s_tvalid;
			C_FUNC_CLR:  take = (func_q == FN_CLEAR);
			C_FUNC_INS:  take = (func_q == FN_INSERT);
			C_FUNC_LKP:  take = (func_q == FN_LOOKUP);
			C_KEY_ZERO:  take = (key_q == '0);
			C_SCAN_RUN:  take = scan_run;
			C_FOUND:     take = found_q;
			C_NO_MATCH:  take = (nmatch_q == 2'd0);
			C_ONE_MATCH: take = (nmatch_q == 2'd1) || (total_q == '0);
			C_MOD_RUN:   take = mod_busy;
			C_OUT_BUSY:  take = out_busy;
			default:     take = 1'b0;
		endcase
		upc_next = take ? uw.target : upc_q + 1'b1;
	end

	// Modulo of the random value by the total count.
	kwp_mod #(
		.TOTAL_W(TW)
	) u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (uw.op == OP_MOD_START),
		.dividend  (rnd_q),
		.divisor   (total_q),
		.busy      (mod_busy),
		.remainder (mod_rem)
	);

	// Table memory: one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			key_mem[mem_waddr]  <= key_q;
			move_mem[mem_waddr] <= move_q;
			hits_mem[mem_waddr] <= mem_whits;
		end
		rd_key_s1  <= key_mem[idx_q[AW-1:0]];
		rd_move_s1 <= move_mem[idx_q[AW-1:0]];
		rd_hits_s1 <= hits_mem[idx_q[AW-1:0]];
		rd_idx_s1  <= idx_q[AW-1:0];
	end

	// Sequencer control state, fill count and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q      <= U_IDLE;
			used_q     <= '0;
			idx_q      <= '0;
			rd_vld_s1  <= 1'b0;
			found_q    <= 1'b0;
			nmatch_q   <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			upc_q     <= upc_next;
			rd_vld_s1 <= issue;
			if (issue) begin
				idx_q <= idx_q + 1'b1;
			end
			// A new result loads the output register once it is free.
			if ((uw.op == OP_EMIT) && !out_busy) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (uw.op)
				OP_START: begin
					if (accept) begin
						idx_q    <= '0;
						found_q  <= 1'b0;
						nmatch_q <= '0;
					end
				end
				OP_CLEAR: begin
					used_q <= '0;
				end
				OP_SCAN_INS: begin
					if (ins_hit) begin
						found_q <= 1'b1;
					end
				end
				OP_APPEND: begin
					if (!table_full) begin
						used_q <= used_q + 1'b1;
					end
				end
				OP_SCAN_SUM: begin
					if (key_hit && (nmatch_q != 2'd2)) begin
						nmatch_q <= nmatch_q + 1'b1;
					end
				end
				OP_MOD_START: begin
					idx_q   <= '0;
					found_q <= 1'b0;
				end
				OP_SCAN_PICK: begin
					if (pick_hit) begin
						found_q <= 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Request latch, sums and result payload.
	always_ff @(posedge clk) begin
		unique case (uw.op)
			OP_START: begin
				if (accept) begin
					func_q       <= s_tuser;
					key_q        <= s_tdata[KEY_W-1:0];
					move_q       <= s_tdata[KEY_W +: MOVE_W];
					rnd_q        <= s_tdata[KEY_W+MOVE_W +: RND_W];
					total_q      <= '0;
					res_move_q   <= '0;
					res_status_q <= STAT_OK;
				end
			end
			OP_APPEND: begin
				if (table_full) begin
					res_status_q <= STAT_FULL;
				end
			end
			OP_SCAN_SUM: begin
				if (key_hit) begin
					total_q <= total_q + TW'(rd_hits_s1);
					if (nmatch_q == 2'd0) begin
						first_move_q <= rd_move_s1;
					end
				end
			end
			OP_TAKE_FIRST: begin
				res_move_q <= first_move_q;
			end
			OP_MOD_START: begin
				cum_q <= '0;
			end
			OP_SCAN_PICK: begin
				if (key_hit && !found_q) begin
					cum_q <= pick_cum;
				end
				if (pick_hit) begin
					res_move_q <= rd_move_s1;
				end
			end
			OP_MISS: begin
				res_status_q <= STAT_MISS;
			end
			OP_EMIT: begin
				if (!out_busy) begin
					m_tdata_q <= res_move_q;
					m_tuser_q <= res_status_q;
				end
			end
			default: begin
			end
		endcase
	end

`ifndef SYNTHESIS
	// The fill count never passes the table depth.
	a_used_range: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= CW'(TABLE_DEPTH))
		else $error("fill count beyond table depth");

	// Only filled slots are ever evaluated.
	a_read_filled: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> (CW'(rd_idx_s1) < used_q))
		else $error("evaluated a slot that was never filled");

	// The weighted pick starts with a remainder below the total count.
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		(upc_q == U_PICK) |-> (mod_rem < total_q))
		else $error("modulo result not below the total");

	// The pick pass always lands on a matching slot.
	a_pick_found: assert property (@(posedge clk) disable iff (!arst_n)
		(upc_q == U_PEND) |-> found_q)
		else $error("weighted pick ended without a selection");
`endif

endmodule

// File: bench/tb_top.sv
// Self-checking testbench of the keyed move table with count-weighted lookup.
`timescale 1ns / 100ps

module tb_top;
	import kwp_pkg::*;

	// Table geometry of the block under test.
	localparam int TB_DEPTH    = 1024;
	localparam int TB_HIT_BITS = 16;
	localparam int BUMP_REQS   = 20;
	localparam int TOTAL_REQS  = 290;
	localparam int IDLE_LIMIT  = 20000;
	localparam int HOLD_CYCLES = 400;
	localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [KEY_W-1:0]  key;
		logic [MOVE_W-1:0] mv;
		logic [RND_W-1:0]  rnd;
	} book_req_t;

	typedef struct packed {
		logic [MOVE_W-1:0] move;
		logic [STAT_W-1:0] status;
	} pick_result_t;

	logic                 clk      = 1'b0;
	logic                 arst_n   = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [IN_DATA_W-1:0] s_tdata  = '0;  // position_key, move_code, random_value
	logic [FUNC_W-1:0]    s_tuser  = '0;  // func
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [MOVE_W-1:0]    m_tdata;        // chosen_move
	logic [STAT_W-1:0]    m_tuser;        // status

	// Shadow copy of the table.
	logic [KEY_W-1:0]  tbl_key  [TB_DEPTH];
	logic [MOVE_W-1:0] tbl_move [TB_DEPTH];
	int                tbl_hits [TB_DEPTH];

	book_req_t    req_backlog[$];
	pick_result_t expected_picks[$];
	book_req_t    cur_req;
	int           reqs_taken   = 0;
	int           results_seen = 0;
	int           err_count    = 0;
	int           hold_left    = 0;
	bit           hold_done    = 1'b0;
	int           stall_cycles = 0;

	keyed_table_weighted_pick #(
		.TABLE_DEPTH(TB_DEPTH),
		.HIT_BITS   (TB_HIT_BITS)
	) u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	task automatic flag_error(input string msg);
		$display("ERROR at %0t: %s", $realtime, msg);
		err_count++;
	endtask

	task automatic queue_req(input logic [FUNC_W-1:0] f, input logic [KEY_W-1:0] k,
			input logic [MOVE_W-1:0] m, input logic [RND_W-1:0] r);
		book_req_t req;
		req.func = f;
		req.key  = k;
		req.mv   = m;
		req.rnd  = r;
		req_backlog.push_back(req);
	endtask

	// Applies one request to the shadow table and returns the result the block must give.
	function automatic pick_result_t predict_pick(input book_req_t req);
		pick_result_t    res;
		longint unsigned total;
		longint unsigned cum;
		longint unsigned r;
		int              match_cnt;
		int              first;
		bit              picked;
		res.move   = '0;
		res.status = STAT_OK;
		case (req.func)
			FN_CLEAR: begin
				for (int i = 0; i < TB_DEPTH; i++) begin
					tbl_key[i]  = '0;
					tbl_hits[i] = 0;
				end
			end
			FN_INSERT: begin
				// A zero key is dropped silently; otherwise bump a matching pair or take the
				// first empty slot, and report full when neither exists.
				if (req.key != '0) begin
					res.status = STAT_FULL;
					for (int i = 0; i < TB_DEPTH && res.status == STAT_FULL; i++) begin
						if (tbl_key[i] == req.key && tbl_move[i] == req.mv) begin
							if (tbl_hits[i] < (1 << TB_HIT_BITS) - 1)
								tbl_hits[i]++;
							res.status = STAT_OK;
						end else if (tbl_key[i] == '0) begin
							tbl_key[i]  = req.key;
							tbl_move[i] = req.mv;
							tbl_hits[i] = 1;
							res.status  = STAT_OK;
						end
					end
				end
			end
			FN_LOOKUP: begin
				res.status = STAT_MISS;
				if (req.key != '0) begin
					total     = 0;
					match_cnt = 0;
					first     = 0;
					for (int i = 0; i < TB_DEPTH; i++) begin
						if (tbl_key[i] == req.key) begin
							if (match_cnt == 0)
								first = i;
							match_cnt++;
							total += tbl_hits[i];
						end
					end
					if (match_cnt != 0) begin
						res.status = STAT_OK;
						res.move   = tbl_move[first];
						// Several matches: first one whose running count exceeds rnd mod total.
						if (match_cnt > 1 && total != 0) begin
							r      = {32'd0, req.rnd} % total;
							cum    = 0;
							picked = 1'b0;
							for (int i = first; i < TB_DEPTH; i++) begin
								if (!picked && tbl_key[i] == req.key) begin
									cum += tbl_hits[i];
									if (r < cum) begin
										res.move = tbl_move[i];
										picked   = 1'b1;
									end
								end
							end
						end
					end
				end
			end
			default: begin
			end
		endcase
		return res;
	endfunction

	// Request driver: holds each request until it is taken, then predicts its result.
	always @(posedge clk) begin : req_driver
		int idle_pct;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				expected_picks.push_back(predict_pick(cur_req));
				reqs_taken++;
			end
			idle_pct = (reqs_taken >= 120 && reqs_taken < 180) ? 0 : 12;
			if (!s_tvalid || s_tready) begin
				if (req_backlog.size() != 0 && $urandom_range(99) >= idle_pct) begin
					cur_req  = req_backlog.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= {cur_req.rnd, cur_req.mv, cur_req.key};
					s_tuser  <= cur_req.func;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: checks each result against the oldest prediction and paces m_tready.
	always @(posedge clk) begin : result_monitor
		pick_result_t want;
		int idle_pct;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_picks.size() == 0) begin
					flag_error($sformatf("unexpected result: move %h status %0d", m_tdata, m_tuser));
				end else begin
					want = expected_picks.pop_front();
					if (m_tdata !== want.move)
						flag_error($sformatf("result %0d: chosen_move %h, expected %h",
							results_seen, m_tdata, want.move));
					if (m_tuser !== want.status)
						flag_error($sformatf("result %0d: status %0d, expected %0d",
							results_seen, m_tuser, want.status));
				end
				results_seen++;
			end
			idle_pct = (results_seen >= 120 && results_seen < 180) ? 0 : 12;
			// One long stall so the block backs up and stops taking requests.
			if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				m_tready  <= 1'b0;
			end else if (!hold_done && results_seen == 40) begin
				hold_done <= 1'b1;
				hold_left <= HOLD_CYCLES;
				m_tready  <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= idle_pct);
			end
		end
	end

	// Watchdog on cycles with no handshake on either side.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= IDLE_LIMIT) begin
				$display("ERROR: no handshake for %0d cycles", IDLE_LIMIT);
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	initial begin
		logic [KEY_W-1:0]  k1;
		logic [KEY_W-1:0]  k2;
		logic [KEY_W-1:0]  keys [6];
		logic [MOVE_W-1:0] moves [3];
		int                kind;
		int                n;
		bit                first_ep;

		for (int i = 0; i < TB_DEPTH; i++) begin
			tbl_key[i]  = '0;
			tbl_hits[i] = 0;
		end

		// Directed requests: empty table, zero keys, unused code, non-adjacent matches,
		// both ends of the weighted pick and repeated hits on one pair.
		k1 = '1;
		k2 = 64'h0000_0000_0000_0001;
		queue_req(FN_LOOKUP, k1, '0, '0);
		queue_req(FN_LOOKUP, '0, '1, '1);
		queue_req(FN_INSERT, '0, '1, '0);
		queue_req(FN_UNUSED, '1, '1, '1);
		queue_req(FN_INSERT, k1, 16'hFFFF, '0);
		queue_req(FN_LOOKUP, k1, '0, 32'hFFFF_FFFF);
		queue_req(FN_INSERT, k2, 16'h0001, '0);
		queue_req(FN_INSERT, k1, 16'h1234, '0);
		queue_req(FN_LOOKUP, k1, '0, 32'h0000_0000);
		queue_req(FN_LOOKUP, k1, '0, 32'hFFFF_FFFF);
		for (int i = 0; i < BUMP_REQS; i++)
			queue_req(FN_INSERT, k1, 16'h1234, $urandom);
		queue_req(FN_LOOKUP, k1, '0, 32'd15);
		queue_req(FN_LOOKUP, k1, '0, 32'd16);
		queue_req(FN_CLEAR, '1, '1, '1);
		queue_req(FN_LOOKUP, k1, '0, '0);

		// Random part as episodes: mostly a clear, then a dense run on few pairs, a long run of
		// inserts over many pairs, or noise with every code and zero keys.
		first_ep = 1'b1;
		while (req_backlog.size() < TOTAL_REQS) begin
			kind = first_ep ? 5 : $urandom_range(9);
			first_ep = 1'b0;
			for (int i = 0; i < 6; i++)
				keys[i] = {$urandom, $urandom};
			for (int i = 0; i < 3; i++)
				moves[i] = MOVE_W'($urandom);
			if ($urandom_range(9) != 0)
				queue_req(FN_CLEAR, {$urandom, $urandom}, MOVE_W'($urandom), $urandom);
			if (kind < 4) begin
				n = $urandom_range(20, 40);
				for (int i = 0; i < n; i++) begin
					if ($urandom_range(99) < 70)
						queue_req(FN_INSERT, keys[$urandom_range(1)], moves[$urandom_range(1)],
							$urandom);
					else
						queue_req(FN_LOOKUP, keys[$urandom_range(2)], MOVE_W'($urandom),
							$urandom);
				end
			end else if (kind < 7) begin
				n = $urandom_range(30, 45);
				for (int i = 0; i < n; i++)
					queue_req(FN_INSERT, keys[$urandom_range(5)], MOVE_W'($urandom), $urandom);
				for (int i = 0; i < 6; i++)
					queue_req(FN_LOOKUP, keys[$urandom_range(5)], MOVE_W'($urandom), $urandom);
			end else begin
				n = $urandom_range(8, 16);
				for (int i = 0; i < n; i++) begin
					case ($urandom_range(3))
						0: queue_req(FUNC_W'($urandom_range(3)), '0, MOVE_W'($urandom),
							$urandom);
						1: queue_req(FUNC_W'($urandom_range(3)), {$urandom, $urandom},
							MOVE_W'($urandom), $urandom);
						default: queue_req(FUNC_W'($urandom_range(3)), keys[$urandom_range(5)],
							moves[0], $urandom);
					endcase
				end
			end
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Drain: every request taken, every result back, then a quiet tail.
		while (req_backlog.size() != 0 || s_tvalid)
			@(posedge clk);
		while (expected_picks.size() != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
		if (expected_picks.size() != 0)
			flag_error($sformatf("%0d results never arrived", expected_picks.size()));
		if (err_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
